/* rtl/core/spma_pkg.sv */
// ----------------------------------------------------------------------------
// spma_pkg
// Shared types and constants for the spectrum peak and mean accumulator.
// ----------------------------------------------------------------------------
package spma_pkg;

  localparam int DATA_W = 16;
  localparam int IDX_W  = 10;
  localparam int BIU_W  = 11;
  localparam int CFG_W  = 16;
  localparam int QUO_W  = 17;

  localparam logic CFG_BINS_IN_USE = 1'b0;
  localparam logic CFG_PEAK_FLOOR  = 1'b1;

  localparam logic [BIU_W-1:0]         BIU_RESET   = 11'd1024;
  localparam logic signed [DATA_W-1:0] FLOOR_RESET = -16'sd30720;

  typedef struct packed {
    logic accept;
    logic update;
    logic mul1;
    logic mul2;
    logic load_out;
  } spma_cmd_t;

  typedef struct packed {
    logic recip_busy;
    logic out_free;
  } spma_stat_t;

endpackage

/* rtl/core/spectrum_peak_and_mean_accumulator_core.sv */
// Sequencing: a request steps through the update, mul1, mul2 and fix states,
// then its result is registered once the output is free; no new request is
// taken meanwhile. The first bin of a row that raises the used-row count
// waits in mul1 for the iterative reciprocal of the count, one bit per cycle.
// Reset: synchronous rst clears control, row state and configuration to their
// defaults; stored bins read as empty through a fill count, with no clear pass.
// ----------------------------------------------------------------------------
// spectrum_peak_and_mean_accumulator_core
// Per-bin peak hold and cumulative mean over spectrum rows in Q8.8 dB.
// ----------------------------------------------------------------------------
module spectrum_peak_and_mean_accumulator_core #(
  parameter int BINS     = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [spma_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [spma_pkg::DATA_W-1:0] sample_db,
  input  logic                               peak_use,
  input  logic                               mean_use,
  input  logic                               new_set,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spma_pkg::IDX_W-1:0]         bin_index,
  output logic signed [spma_pkg::DATA_W-1:0] peak_db,
  output logic signed [spma_pkg::DATA_W-1:0] mean_db,
  output logic                               last_in_row
);

  spma_pkg::spma_cmd_t  cmd;
  spma_pkg::spma_stat_t stat;

  spma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spma_datapath #(
    .BINS     (BINS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_db   (sample_db),
    .peak_use    (peak_use),
    .mean_use    (mean_use),
    .new_set     (new_set),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bin_index   (bin_index),
    .peak_db     (peak_db),
    .mean_db     (mean_db),
    .last_in_row (last_in_row)
  );

endmodule

/* rtl/core/spma_recip.sv */
// ----------------------------------------------------------------------------
// spma_recip
// Iterative reciprocal unit: forms floor(2**K / divisor), one bit per cycle.
// ----------------------------------------------------------------------------
module spma_recip #(
  parameter int DW = 13,
  parameter int K  = 28
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [K:0]    recip
);

  localparam int CNTW = $clog2(K + 2);

  logic [DW-1:0]   div_r;
  logic [DW-1:0]   rem;
  logic [K:0]      quo;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_dif;
  logic            fits;

  always_comb begin
    rem_sh  = {rem, (cnt == '0)};
    fits    = rem_sh >= {1'b0, div_r};
    rem_dif = rem_sh - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (cnt == CNTW'(K))) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem   <= '0;
      quo   <= '0;
      cnt   <= '0;
    end else if (busy) begin
      rem <= fits ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
      quo <= {quo[K-1:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

  assign recip = quo;

endmodule

/* rtl/core/spma_datapath.sv */
// ----------------------------------------------------------------------------
// spma_datapath
// Bin store, row tracking, peak and sum update, and the mean divider path.
// ----------------------------------------------------------------------------
module spma_datapath #(
  parameter int BINS     = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  spma_pkg::spma_cmd_t                cmd,
  output spma_pkg::spma_stat_t               stat,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [spma_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [spma_pkg::DATA_W-1:0] sample_db,
  input  logic                               peak_use,
  input  logic                               mean_use,
  input  logic                               new_set,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spma_pkg::IDX_W-1:0]         bin_index,
  output logic signed [spma_pkg::DATA_W-1:0] peak_db,
  output logic signed [spma_pkg::DATA_W-1:0] mean_db,
  output logic                               last_in_row
);

  localparam int DW   = spma_pkg::DATA_W;
  localparam int QW   = spma_pkg::QUO_W;
  localparam int PW   = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int FW   = $clog2(BINS + 1);
  localparam int NW   = (FW > spma_pkg::BIU_W) ? FW : spma_pkg::BIU_W;
  localparam int CW   = $clog2(MAX_ROWS + 1);
  localparam int SW   = DW + $clog2(MAX_ROWS);
  localparam int RW   = SW + 1;
  localparam int PRW  = SW + RW;
  localparam int QDW  = QW + CW;
  localparam int MW   = SW + DW;

  // Configuration registers.
  logic [spma_pkg::BIU_W-1:0] bins_in_use;
  logic signed [DW-1:0]       peak_floor;

  // Row tracking.
  logic [PW-1:0] bin_position;
  logic [FW-1:0] fill;
  logic [CW-1:0] row_count;
  logic          row_peak;
  logic          row_mean;

  // Item registers.
  logic signed [DW-1:0] sample_r;
  logic [PW-1:0]        pos_r;
  logic                 last_r;
  logic signed [DW-1:0] peak_r;
  logic signed [SW-1:0] sum_r;
  logic [SW-1:0]        a_r;
  logic                 neg_r;
  logic [PRW-1:0]       prod_r;
  logic [QW-1:0]        q0_r;
  logic [QDW-1:0]       qd_r;

  logic [MW-1:0] mem [BINS];
  logic [MW-1:0] rd_q;

  // Accept-side logic.
  logic [PW-1:0] pos_cur;
  logic [CW-1:0] count_base;
  logic          row_start;
  logic          mean_start;
  logic [NW-1:0] biu_ext;
  logic [NW-1:0] n_active;
  logic [NW-1:0] pos_inc;
  logic          last_cur;

  // Update-side logic.
  logic                 entry_valid;
  logic signed [DW-1:0] rd_peak;
  logic signed [SW-1:0] rd_sum;
  logic signed [DW-1:0] peak_base;
  logic signed [SW-1:0] sum_base;
  logic signed [DW-1:0] peak_new;
  logic signed [SW-1:0] sum_new;
  logic [FW-1:0]        fill_inc;

  // Mean path.
  logic [RW-1:0]  recip;
  logic           recip_busy;
  logic [SW-1:0]  sum_mag;
  logic [PRW-1:0] prod_c;
  logic [QW-1:0]  q0;
  logic [QDW-1:0] qd_c;
  logic [SW-1:0]  rem;
  logic           round_up;
  logic [QW-1:0]  q_fin;
  logic [DW-1:0]  mean_mag;
  logic [DW-1:0]  mean_val;

  always_comb begin
    pos_cur    = new_set ? '0 : bin_position;
    count_base = new_set ? '0 : row_count;
    row_start  = (pos_cur == '0);
    mean_start = row_start && mean_use && (count_base < CW'(MAX_ROWS));
    biu_ext    = NW'(bins_in_use);
    if (biu_ext == '0) begin
      n_active = NW'(1);
    end else if (biu_ext > NW'(BINS)) begin
      n_active = NW'(BINS);
    end else begin
      n_active = biu_ext;
    end
    pos_inc  = NW'(pos_cur) + NW'(1);
    last_cur = pos_inc >= n_active;
  end

  always_comb begin
    entry_valid = FW'(pos_r) < fill;
    rd_peak     = rd_q[DW-1:0];
    rd_sum      = rd_q[MW-1:DW];
    peak_base   = entry_valid ? rd_peak : peak_floor;
    sum_base    = entry_valid ? rd_sum : '0;
    peak_new    = (row_peak && (sample_r > peak_base)) ? sample_r : peak_base;
    sum_new     = row_mean ? (sum_base + SW'(sample_r)) : sum_base;
    fill_inc    = FW'(pos_r) + FW'(1);
  end

  always_comb begin
    sum_mag  = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
    prod_c   = sum_mag * recip;
    q0       = prod_r[SW +: QW];
    qd_c     = q0 * row_count;
    rem      = a_r - SW'(qd_r);
    round_up = rem >= SW'(row_count);
    q_fin    = q0_r + QW'(round_up);
    mean_mag = q_fin[DW-1:0];
    if (row_count == '0) begin
      mean_val = '0;
    end else begin
      mean_val = neg_r ? -mean_mag : mean_mag;
    end
  end

  spma_recip #(
    .DW (CW),
    .K  (SW)
  ) u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.accept && mean_start),
    .divisor (count_base + 1'b1),
    .busy    (recip_busy),
    .recip   (recip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= spma_pkg::BIU_RESET;
      peak_floor  <= spma_pkg::FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        spma_pkg::CFG_BINS_IN_USE: bins_in_use <= cfg_data[spma_pkg::BIU_W-1:0];
        spma_pkg::CFG_PEAK_FLOOR:  peak_floor  <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_position <= '0;
      fill         <= '0;
      row_count    <= '0;
      row_peak     <= 1'b0;
      row_mean     <= 1'b0;
    end else if (cmd.accept) begin
      bin_position <= last_cur ? '0 : pos_inc[PW-1:0];
      row_count    <= mean_start ? (count_base + 1'b1) : count_base;
      if (new_set) begin
        fill <= '0;
      end
      if (row_start) begin
        row_peak <= peak_use;
        row_mean <= mean_start;
      end
    end else if (cmd.update) begin
      if (fill_inc > fill) begin
        fill <= fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_q     <= mem[pos_cur];
      sample_r <= sample_db;
      pos_r    <= pos_cur;
      last_r   <= last_cur;
    end
    if (cmd.update) begin
      mem[pos_r] <= {sum_new, peak_new};
      peak_r     <= peak_new;
      sum_r      <= sum_new;
    end
    if (cmd.mul1) begin
      a_r    <= sum_mag;
      neg_r  <= sum_r[SW-1];
      prod_r <= prod_c;
    end
    if (cmd.mul2) begin
      q0_r <= q0;
      qd_r <= qd_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      bin_index   <= spma_pkg::IDX_W'(pos_r);
      peak_db     <= peak_r;
      mean_db     <= mean_val;
      last_in_row <= last_r;
    end
  end

  assign stat.recip_busy = recip_busy;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

/* rtl/core/spma_ctrl.sv */
// ----------------------------------------------------------------------------
// spma_ctrl
// Sequencer that steps one request through update, multiply and output.
// ----------------------------------------------------------------------------
module spma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spma_pkg::spma_stat_t stat,
  output spma_pkg::spma_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_MUL1   = 5'b00100,
    S_MUL2   = 5'b01000,
    S_FIX    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        if (!stat.recip_busy) begin
          cmd.mul1   = 1'b1;
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/spma_checker.sv */
// ----------------------------------------------------------------------------
// spma_checker
// Port-level checks on request sequencing and result hold for the core.
// ----------------------------------------------------------------------------
module spma_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [spma_pkg::IDX_W-1:0]         bin_index,
  input logic signed [spma_pkg::DATA_W-1:0] peak_db,
  input logic signed [spma_pkg::DATA_W-1:0] mean_db,
  input logic                               last_in_row
);

  a_reset_clears_result: assert property (
    @(posedge clk) rst |=> !out_valid
  ) else $error("Result valid after reset.");

  a_result_holds: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(bin_index) && $stable(peak_db)
      && $stable(mean_db) && $stable(last_in_row))
  ) else $error("Stalled result changed.");

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("Request taken while the previous one is in work.");

  a_min_item_time: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##4 !in_ready
  ) else $error("Request finished faster than the datapath allows.");

endmodule

bind spectrum_peak_and_mean_accumulator_core spma_checker u_spma_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .bin_index   (bin_index),
  .peak_db     (peak_db),
  .mean_db     (mean_db),
  .last_in_row (last_in_row)
);
